[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the balancer checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define P2C_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define P2C_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/p2c_pkg.sv]
// ----------------------------------------------------------------------------
// p2c_pkg
// sizes, field layout, codes and shared types of the two-choice balancer
// ----------------------------------------------------------------------------
package p2c_pkg;

    // table geometry
    localparam int NUM_BACKENDS = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int SLOT_W       = $clog2(NUM_BACKENDS);
    localparam int CNT_W        = $clog2(NUM_BACKENDS + 1);

    // request field widths
    localparam int IDX_FIELD_W  = 4;
    localparam int CONN_FIELD_W = 16;
    localparam int RAND_W       = 16;
    localparam int STEP_W       = $clog2(RAND_W);

    // request tdata layout
    localparam int I_IDX_LSB    = 0;
    localparam int I_HLTH_BIT   = I_IDX_LSB + IDX_FIELD_W;
    localparam int I_CONN_LSB   = I_HLTH_BIT + 1;
    localparam int I_RND1_LSB   = I_CONN_LSB + CONN_FIELD_W;
    localparam int I_RND2_LSB   = I_RND1_LSB + RAND_W;
    localparam int I_USED_W     = I_RND2_LSB + RAND_W;
    localparam int S_TDATA_W    = ((I_USED_W + 7) / 8) * 8;

    // result tdata layout
    localparam int OUT_SLOT_W   = 4;
    localparam int O_FOUND_BIT  = 0;
    localparam int O_CHOSEN_LSB = 1;
    localparam int O_FIRST_LSB  = O_CHOSEN_LSB + OUT_SLOT_W;
    localparam int O_SECOND_LSB = O_FIRST_LSB + OUT_SLOT_W;
    localparam int O_FALLBK_BIT = O_SECOND_LSB + OUT_SLOT_W;
    localparam int O_USED_W     = O_FALLBK_BIT + 1;
    localparam int M_TDATA_W    = ((O_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - O_USED_W;

    // request kinds carried in tuser
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CHOOSE = 1'b1;

    // remainder unit request and response
    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_mod_rsp;

endpackage

[sv/p2c_ram.sv]
// ----------------------------------------------------------------------------
// p2c_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module p2c_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/p2c_mod.sv]
// ----------------------------------------------------------------------------
// p2c_mod
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module p2c_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  p2c_pkg::t_mod_req i_req,
    output p2c_pkg::t_mod_rsp o_rsp
);

    import p2c_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RAND_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RAND_W-1:0] r_dvd;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_rem;

    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  n_rem;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_dvd[RAND_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = CNT_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = CNT_W'(trial);
        end
    end

    // control: busy flag and one-cycle done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_div  <= i_req.divisor;
            r_rem  <= '0;
            r_step <= STEP_LAST;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[RAND_W-2:0], 1'b0};
            r_step <= r_step - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

[sv/power_of_two_choices_balancer_top.sv]
// ----------------------------------------------------------------------------
// power_of_two_choices_balancer_top
// backend table with two-random-choice least-connections selection
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel. tuser selects the kind: an update
// writes one slot's healthy mark and connection count and gives no result; a
// choose request gives one result on the m_axis channel.
// An update leaves s_axis_tready high for the next request.
// A choose request walks the healthy marks once to count them, runs two
// remainders through the shared bit-serial unit, walks the marks again to
// find both candidates and reads both counts from the table memory. With
// no healthy slot it goes straight to the result; with one it skips the
// remainders and the count reads. s_axis_tready is low for the whole
// choose request. Results sit in an output register; while the receiver
// stalls, the block still takes requests, but a finished choice waits
// until the register frees, and s_axis_tready stays low meanwhile.
// Reset marks every slot unhealthy and empties the output register.
// ----------------------------------------------------------------------------
module power_of_two_choices_balancer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index, entry_healthy, entry_connections, rand_first, rand_second
    input  logic [p2c_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // found, chosen, first_pick, second_pick, single_fallback
    output logic [p2c_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    import p2c_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_COUNT     = 4'd1;
    localparam logic [3:0] S_MOD1_GO   = 4'd2;
    localparam logic [3:0] S_MOD1_WAIT = 4'd3;
    localparam logic [3:0] S_MOD2_GO   = 4'd4;
    localparam logic [3:0] S_MOD2_WAIT = 4'd5;
    localparam logic [3:0] S_SCAN      = 4'd6;
    localparam logic [3:0] S_RDA       = 4'd7;
    localparam logic [3:0] S_RDB       = 4'd8;
    localparam logic [3:0] S_CMP       = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BACKENDS - 1);

    // control registers
    logic [3:0]              r_state, n_state;
    logic [NUM_BACKENDS-1:0] r_healthy, n_healthy;
    logic                    r_out_valid, n_out_valid;

    // working registers
    logic [SLOT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]        r_n, n_n;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic [CNT_W-1:0]        r_k1, n_k1;
    logic [CNT_W-1:0]        r_k2, n_k2;
    logic [SLOT_W-1:0]       r_a, n_a;
    logic [SLOT_W-1:0]       r_b, n_b;
    logic [RAND_W-1:0]       r_rand1, n_rand1;
    logic [RAND_W-1:0]       r_rand2, n_rand2;
    logic                    r_fallback, n_fallback;
    logic                    r_found, n_found;
    logic [SLOT_W-1:0]       r_chosen, n_chosen;
    logic [COUNT_WIDTH-1:0]  r_cnt_a, n_cnt_a;
    logic [M_TDATA_W-1:0]    r_out_data, n_out_data;

    // request fields
    logic [IDX_FIELD_W-1:0]  in_idx;
    logic                    in_healthy;
    logic [CONN_FIELD_W-1:0] in_conn;
    logic                    in_accept;
    logic                    idx_ok;
    logic [SLOT_W-1:0]       wr_slot;

    // table memory and remainder unit
    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_rdata;
    t_mod_req                mod_req;
    t_mod_rsp                mod_rsp;

    logic [CNT_W-1:0]        rem2;
    logic                    out_load;

    assign in_idx     = s_axis_tdata[I_IDX_LSB +: IDX_FIELD_W];
    assign in_healthy = s_axis_tdata[I_HLTH_BIT];
    assign in_conn    = s_axis_tdata[I_CONN_LSB +: CONN_FIELD_W];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign idx_ok     = int'(in_idx) < NUM_BACKENDS;
    assign wr_slot    = SLOT_W'(in_idx);
    assign ram_we     = in_accept && (s_axis_tuser == OP_UPDATE) && idx_ok;
    assign ram_raddr  = (r_state == S_RDA) ? r_a : r_b;

    // remainder requests: first pick over n, second over n - 1
    assign mod_req.start    = (r_state == S_MOD1_GO) || (r_state == S_MOD2_GO);
    assign mod_req.dividend = (r_state == S_MOD1_GO) ? r_rand1 : r_rand2;
    assign mod_req.divisor  = (r_state == S_MOD1_GO) ? r_n : (r_n - 1'b1);

    assign rem2     = mod_rsp.rem;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_healthy  = r_healthy;
        n_idx      = r_idx;
        n_n        = r_n;
        n_seen     = r_seen;
        n_k1       = r_k1;
        n_k2       = r_k2;
        n_a        = r_a;
        n_b        = r_b;
        n_rand1    = r_rand1;
        n_rand2    = r_rand2;
        n_fallback = r_fallback;
        n_found    = r_found;
        n_chosen   = r_chosen;
        n_cnt_a    = r_cnt_a;
        n_out_data = r_out_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (s_axis_tuser == OP_UPDATE) begin
                        if (idx_ok) begin
                            n_healthy[wr_slot] = in_healthy;
                        end
                    end else begin
                        n_rand1 = s_axis_tdata[I_RND1_LSB +: RAND_W];
                        n_rand2 = s_axis_tdata[I_RND2_LSB +: RAND_W];
                        n_idx   = '0;
                        n_n     = '0;
                        n_state = S_COUNT;
                    end
                end
            end
            // count healthy slots one per cycle
            S_COUNT: begin
                n_n = r_n + CNT_W'(r_healthy[r_idx]);
                if (r_idx == LAST_SLOT) begin
                    n_idx      = '0;
                    n_seen     = '0;
                    n_fallback = 1'b0;
                    n_found    = 1'b1;
                    if (n_n == '0) begin
                        n_found  = 1'b0;
                        n_chosen = '0;
                        n_a      = '0;
                        n_b      = '0;
                        n_state  = S_DONE;
                    end else if (n_n == CNT_W'(1)) begin
                        n_fallback = 1'b1;
                        n_k1       = '0;
                        n_k2       = '0;
                        n_state    = S_SCAN;
                    end else begin
                        n_state = S_MOD1_GO;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MOD1_GO: begin
                n_state = S_MOD1_WAIT;
            end
            S_MOD1_WAIT: begin
                if (mod_rsp.done) begin
                    n_k1    = mod_rsp.rem;
                    n_state = S_MOD2_GO;
                end
            end
            S_MOD2_GO: begin
                n_state = S_MOD2_WAIT;
            end
            // second pick steps past the first
            S_MOD2_WAIT: begin
                if (mod_rsp.done) begin
                    n_k2    = (rem2 >= r_k1) ? (rem2 + 1'b1) : rem2;
                    n_state = S_SCAN;
                end
            end
            // locate both candidates by healthy rank
            S_SCAN: begin
                if (r_healthy[r_idx]) begin
                    if (r_seen == r_k1) begin
                        n_a = r_idx;
                    end
                    if (r_seen == r_k2) begin
                        n_b = r_idx;
                    end
                    n_seen = r_seen + 1'b1;
                end
                if (r_idx == LAST_SLOT) begin
                    if (r_fallback) begin
                        n_chosen = n_a;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_RDA;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                n_cnt_a = ram_rdata;
                n_state = S_CMP;
            end
            // fewer connections wins, first pick on a tie
            S_CMP: begin
                n_chosen = (r_cnt_a <= ram_rdata) ? r_a : r_b;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_data = {M_PAD_W'(0), r_fallback, OUT_SLOT_W'(r_b),
                                  OUT_SLOT_W'(r_a), OUT_SLOT_W'(r_chosen), r_found};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    assign n_out_valid = out_load || (r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_healthy   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_healthy   <= n_healthy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_seen     <= n_seen;
        r_k1       <= n_k1;
        r_k2       <= n_k2;
        r_a        <= n_a;
        r_b        <= n_b;
        r_rand1    <= n_rand1;
        r_rand2    <= n_rand2;
        r_fallback <= n_fallback;
        r_found    <= n_found;
        r_chosen   <= n_chosen;
        r_cnt_a    <= n_cnt_a;
        r_out_data <= n_out_data;
    end

    // connection counts; a slot is read only after it has been written healthy
    p2c_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BACKENDS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_slot),
        .i_wdata (COUNT_WIDTH'(in_conn)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    p2c_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[sv/p2c_checker.sv]
// ----------------------------------------------------------------------------
// p2c_checker
// port-level checks of the balancer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module p2c_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [p2c_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import p2c_pkg::*;

    logic                  found;
    logic                  fallback;
    logic [OUT_SLOT_W-1:0] chosen;
    logic [OUT_SLOT_W-1:0] first_pick;
    logic [OUT_SLOT_W-1:0] second_pick;
    logic                  choose_req;

    assign found       = m_axis_tdata[O_FOUND_BIT];
    assign fallback    = m_axis_tdata[O_FALLBK_BIT];
    assign chosen      = m_axis_tdata[O_CHOSEN_LSB +: OUT_SLOT_W];
    assign first_pick  = m_axis_tdata[O_FIRST_LSB +: OUT_SLOT_W];
    assign second_pick = m_axis_tdata[O_SECOND_LSB +: OUT_SLOT_W];
    assign choose_req  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CHOOSE);

    // stalled result holds
    `P2C_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a choice occupies the sequencer
    `P2C_ASSERT_NXT(a_busy_after_choose, i_clk, i_rst_n, choose_req, !s_axis_tready, "ready after choose request")

    // empty table gives an all-zero result
    `P2C_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, m_axis_tvalid && !found, !fallback && (chosen == '0) && (first_pick == '0) && (second_pick == '0), "nonzero fields with none found")

    // fallback names one slot everywhere
    `P2C_ASSERT_IMP(a_fallback_same, i_clk, i_rst_n, m_axis_tvalid && fallback, found && (chosen == first_pick) && (first_pick == second_pick), "fallback slots differ")

    // chosen is one of the candidates
    `P2C_ASSERT_IMP(a_chosen_cand, i_clk, i_rst_n, m_axis_tvalid && found, (chosen == first_pick) || (chosen == second_pick), "chosen is not a candidate")

endmodule

bind power_of_two_choices_balancer_top p2c_checker u_p2c_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/tb_power_of_two_choices_balancer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_of_two_choices_balancer_top
// self-checking bench for the two-choice least-connections balancer
// ----------------------------------------------------------------------------
// Drives update and choose requests on s_axis and keeps a shadow copy of the
// backend table. Every accepted choose request is turned into an expected
// choice, either typed into the directed table or computed from the shadow
// table. Results on m_axis are compared field by field in arrival order.
// A directed table covers empty, single and tie cases and the word extremes.
// Random groups then rebuild the table at varied densities and issue
// chooses. Both handshakes idle at random, and the receiver holds off once
// for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_power_of_two_choices_balancer_top;

    import p2c_pkg::*;

    localparam int  RANDOM_REQUESTS = 1630;
    localparam int  DRAIN_CYCLES    = 250;
    localparam int  HOLD_CYCLES     = 700;
    localparam int  CYCLE_LIMIT     = 2000000;
    localparam int  DIR_ROWS        = 21;

    typedef struct packed {
        logic                  found;
        logic [OUT_SLOT_W-1:0] chosen;
        logic [OUT_SLOT_W-1:0] first_pick;
        logic [OUT_SLOT_W-1:0] second_pick;
        logic                  single_fallback;
    } choice_t;

    typedef struct {
        logic        op;
        logic [3:0]  idx;
        logic        healthy;
        logic [15:0] conns;
        logic [15:0] rand_a;
        logic [15:0] rand_b;
        bit          typed;
        choice_t     res;
    } dir_row_t;

    localparam choice_t NONE_FOUND  = '0;
    localparam choice_t ONLY_SLOT15 = '{1'b1, 4'd15, 4'd15, 4'd15, 1'b1};
    localparam choice_t ONLY_SLOT10 = '{1'b1, 4'd10, 4'd10, 4'd10, 1'b1};

    // dut ports, known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_UPDATE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // shadow backend table
    logic                   backend_healthy [NUM_BACKENDS];
    logic [COUNT_WIDTH-1:0] backend_conns   [NUM_BACKENDS];

    choice_t  pending_choices [$];
    dir_row_t dir_rows [DIR_ROWS];
    int       mismatches  = 0;
    int       cycle_count = 0;
    bit       hold_go     = 1'b0;
    bit       hold_active = 1'b0;

    power_of_two_choices_balancer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[power_of_two_choices_balancer_top] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        mismatches++;
    endtask

    // two-choice selection over the shadow table
    function automatic choice_t predict_choice(input logic [15:0] rand_a,
                                               input logic [15:0] rand_b);
        choice_t     res;
        int unsigned n;
        int unsigned k1;
        int unsigned k2;
        int          slots [NUM_BACKENDS];
        int          a;
        int          b;
        res = '0;
        n   = 0;
        for (int i = 0; i < NUM_BACKENDS; i++) begin
            if (backend_healthy[i]) begin
                slots[n] = i;
                n++;
            end
        end
        if (n == 0) return res;
        res.found = 1'b1;
        if (n == 1) begin
            res.chosen          = OUT_SLOT_W'(slots[0]);
            res.first_pick      = OUT_SLOT_W'(slots[0]);
            res.second_pick     = OUT_SLOT_W'(slots[0]);
            res.single_fallback = 1'b1;
            return res;
        end
        k1 = rand_a % n;
        k2 = rand_b % (n - 1);
        // second candidate steps past the first
        if (k2 >= k1) k2++;
        a = slots[k1];
        b = slots[k2];
        res.first_pick  = OUT_SLOT_W'(a);
        res.second_pick = OUT_SLOT_W'(b);
        res.chosen      = (backend_conns[a] <= backend_conns[b]) ? OUT_SLOT_W'(a)
                                                                 : OUT_SLOT_W'(b);
        return res;
    endfunction

    // random word, extremes now and then
    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // one request on s_axis, then an optional gap
    task automatic issue(input logic op, input logic [3:0] idx, input logic healthy,
                         input logic [15:0] conns, input logic [15:0] rand_a,
                         input logic [15:0] rand_b, input bit typed,
                         input choice_t typed_res, input bit no_gap);
        logic [S_TDATA_W-1:0] d;
        int                   r;
        int                   gap;
        d = '0;
        d[I_IDX_LSB +: IDX_FIELD_W]   = idx;
        d[I_HLTH_BIT]                 = healthy;
        d[I_CONN_LSB +: CONN_FIELD_W] = conns;
        d[I_RND1_LSB +: RAND_W]       = rand_a;
        d[I_RND2_LSB +: RAND_W]       = rand_b;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        // accepted at this edge
        if (op == OP_UPDATE) begin
            if (idx < NUM_BACKENDS) begin
                backend_healthy[idx] = healthy;
                backend_conns[idx]   = COUNT_WIDTH'(conns);
            end
        end else begin
            pending_choices.insert(pending_choices.size(),
                                   typed ? typed_res : predict_choice(rand_a, rand_b));
        end
        r = $urandom_range(0, 99);
        if (r < 60)      gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else             gap = $urandom_range(20, 60);
        if (no_gap || hold_active) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        choice_t got;
        choice_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[O_FOUND_BIT],
                    m_axis_tdata[O_CHOSEN_LSB +: OUT_SLOT_W],
                    m_axis_tdata[O_FIRST_LSB +: OUT_SLOT_W],
                    m_axis_tdata[O_SECOND_LSB +: OUT_SLOT_W],
                    m_axis_tdata[O_FALLBK_BIT]};
            if (pending_choices.size() == 0) begin
                report_mismatch("unexpected result", int'(m_axis_tdata), 0);
            end else begin
                want = pending_choices.pop_front();
                if (got.found != want.found)
                    report_mismatch("found", int'(got.found), int'(want.found));
                if (got.chosen != want.chosen)
                    report_mismatch("chosen", int'(got.chosen), int'(want.chosen));
                if (got.first_pick != want.first_pick)
                    report_mismatch("first_pick", int'(got.first_pick),
                                    int'(want.first_pick));
                if (got.second_pick != want.second_pick)
                    report_mismatch("second_pick", int'(got.second_pick),
                                    int'(want.second_pick));
                if (got.single_fallback != want.single_fallback)
                    report_mismatch("single_fallback", int'(got.single_fallback),
                                    int'(want.single_fallback));
            end
        end
    end

    // receiver ready, random idling plus one long hold-off
    initial begin
        int on_len;
        int off_len;
        int r;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 19);
            on_len = (r == 0) ? $urandom_range(200, 600) : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (on_len) @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 50)      off_len = 0;
            else if (r < 92) off_len = $urandom_range(1, 4);
            else             off_len = $urandom_range(20, 60);
            if (hold_go && !hold_active && off_len >= 0) begin
                if (!hold_active && hold_go) begin
                    off_len     = HOLD_CYCLES;
                    hold_active = 1'b1;
                end
            end
            if (off_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (off_len) @(posedge i_clk);
            end
            if (off_len == HOLD_CYCLES) begin
                hold_active = 1'b0;
                hold_go     = 1'b0;
            end
        end
    end

    // stimulus
    initial begin
        int          sent;
        int          mode;
        int          n_upd;
        int          n_chs;
        int          density;
        int          lone;
        bit          big_counts;
        bit          no_gap;
        logic        op;
        logic [3:0]  idx;
        logic        healthy;
        logic [15:0] conns;

        for (int i = 0; i < NUM_BACKENDS; i++) begin
            backend_healthy[i] = 1'b0;
            backend_conns[i]   = '0;
        end

        // directed rows: empty table, lone slot, ties, word extremes
        dir_rows[0]  = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, NONE_FOUND};
        dir_rows[1]  = '{OP_UPDATE, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NONE_FOUND};
        dir_rows[2]  = '{OP_CHOOSE, 4'd7,  1'b1, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b1, ONLY_SLOT15};
        dir_rows[3]  = '{OP_UPDATE, 4'd0,  1'b1, 16'h0000, 16'hA5A5, 16'h5A5A, 1'b0, NONE_FOUND};
        dir_rows[4]  = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[5]  = '{OP_CHOOSE, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NONE_FOUND};
        dir_rows[6]  = '{OP_UPDATE, 4'd0,  1'b1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[7]  = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[8]  = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0001, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[9]  = '{OP_UPDATE, 4'd5,  1'b1, 16'h0007, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[10] = '{OP_UPDATE, 4'd10, 1'b1, 16'h0003, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[11] = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[12] = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[13] = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0002, 16'hFFFF, 1'b0, NONE_FOUND};
        dir_rows[14] = '{OP_UPDATE, 4'd15, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[15] = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0001, 16'h0001, 1'b0, NONE_FOUND};
        dir_rows[16] = '{OP_UPDATE, 4'd0,  1'b0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[17] = '{OP_UPDATE, 4'd5,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, NONE_FOUND};
        dir_rows[18] = '{OP_CHOOSE, 4'd0,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, ONLY_SLOT10};
        dir_rows[19] = '{OP_UPDATE, 4'd10, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, NONE_FOUND};
        dir_rows[20] = '{OP_CHOOSE, 4'd15, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, NONE_FOUND};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            issue(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].healthy, dir_rows[i].conns,
                  dir_rows[i].rand_a, dir_rows[i].rand_b, dir_rows[i].typed,
                  dir_rows[i].res, 1'b0);
        end

        // random groups: rebuild all or part of the table, then choose a few times
        hold_go = 1'b1;
        sent    = 0;
        while (sent < RANDOM_REQUESTS) begin
            mode       = $urandom_range(0, 9);
            big_counts = ($urandom_range(0, 2) == 0);
            no_gap     = ($urandom_range(0, 3) == 0);
            lone       = $urandom_range(0, NUM_BACKENDS - 1);
            density    = $urandom_range(0, 100);
            n_upd      = (mode <= 2) ? NUM_BACKENDS : $urandom_range(1, 12);
            for (int k = 0; k < n_upd; k++) begin
                // sweeps give empty, lone and full tables
                if (mode <= 2) begin
                    idx     = 4'(k);
                    healthy = (mode == 2) || (mode == 1 && k == lone);
                end else begin
                    idx     = 4'($urandom_range(0, NUM_BACKENDS - 1));
                    healthy = ($urandom_range(0, 99) < density);
                end
                // noise group mixes chooses into the updates
                op = (mode == 9 && $urandom_range(0, 2) == 0) ? OP_CHOOSE : OP_UPDATE;
                if ($urandom_range(0, 15) == 0) conns = 16'hFFFF;
                else if (big_counts)            conns = 16'($urandom);
                else                            conns = 16'($urandom_range(0, 3));
                issue(op, idx, healthy, conns, pick_word(), pick_word(), 1'b0,
                      NONE_FOUND, no_gap);
                sent++;
            end
            n_chs = $urandom_range(1, 8);
            for (int k = 0; k < n_chs; k++) begin
                issue(OP_CHOOSE, 4'($urandom), 1'($urandom), 16'($urandom),
                      pick_word(), pick_word(), 1'b0, NONE_FOUND, no_gap);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (pending_choices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[power_of_two_choices_balancer_top] OK");
        end else begin
            $display("[power_of_two_choices_balancer_top] ERROR");
        end
        $finish;
    end

endmodule
